// File: rtl/mpfd_pkg.sv
// package for the page framebuffer draw engine
// shared constants, op and color codes, a masked-write byte helper; no dependencies
package mpfd_pkg;

   localparam int SCREEN_COLS_DEF = 128;
   localparam int SCREEN_ROWS_DEF = 64;

   localparam logic [2:0] OP_WRITE = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_FILL  = 3'd2;
   localparam logic [2:0] OP_FLUSH = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   localparam logic [1:0] COLOR_BLACK   = 2'd0;
   localparam logic [1:0] COLOR_WHITE   = 2'd1;
   localparam logic [1:0] COLOR_INVERSE = 2'd2;
   localparam logic [1:0] COLOR_KEEP    = 2'd3;

   localparam logic [7:0] BYTE_ONES = 8'hFF;

   // new byte for a masked write
   function automatic logic [7:0] apply_mask(input logic [7:0] old_b,
                                             input logic [7:0] mask,
                                             input logic [1:0] color);
      logic [7:0] r;
      r = old_b & ~mask;
      if (color == COLOR_WHITE) r = r | mask;
      if (color == COLOR_INVERSE) r = r | ((old_b ^ mask) & mask);
      return r;
   endfunction

endpackage

// File: rtl/mpfd_store.sv
// page framebuffer store with a registered read; the clearing pass after reset is driven by the top level
// depends on mpfd_pkg
module mpfd_store
   import mpfd_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mono_page_framebuffer_draw.sv
// mono_page_framebuffer_draw: one-bit page framebuffer draw engine, top level
// each item runs setup, then a read, wait, modify and next step per byte touched, then
// waits in the output state; pixel, flush, no-op and empty items touch a single byte
// throughput: one item at a time, next item taken the cycle after the result leaves
// reset clears control state, then a clearing pass zeroes all COLS*pages store bytes
// (1024 at defaults); no item is accepted during that pass
// depends on mpfd_pkg, mpfd_store
module mono_page_framebuffer_draw
   import mpfd_pkg::*;
#(
   parameter int SCREEN_COLS = SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_rect_w,
   input  logic signed [15:0] req_rect_h,
   input  logic [1:0]         req_color,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_pixel_on,
   output logic [6:0]         rsp_dirty_left,
   output logic [5:0]         rsp_dirty_top,
   output logic [7:0]         rsp_dirty_width,
   output logic [6:0]         rsp_dirty_height
);

   localparam int PAGES = (SCREEN_ROWS + 7) / 8;
   localparam int DEPTH = SCREEN_COLS * PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(SCREEN_COLS);
   localparam int RW    = $clog2(SCREEN_ROWS);
   localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam logic signed [17:0] COLS_S = 18'(SCREEN_COLS);
   localparam logic signed [17:0] ROWS_S = 18'(SCREEN_ROWS);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_SETUP, S_RD, S_WAIT, S_MOD, S_NEXT, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] rot_ff;
   logic [2:0] op_ff;
   logic [1:0] color_ff;
   logic signed [17:0] x_ff, y_ff, w_ff, h_ff;
   logic [CW-1:0] col_ff, col_lo_ff, col_hi_ff;
   logic [PW-1:0] page_ff, page_hi_ff;
   logic [RW-1:0] py_lo_ff, py_hi_ff;
   logic [AW-1:0] init_ff;
   logic [CW:0] bl_ff, br_ff;
   logic [RW:0] bt_ff, bb_ff;
   logic        skip_ff;
   logic [7:0]  pmask_ff;
   logic        rsp_valid_ff, pix_ff;
   logic [6:0]  o_left_ff;
   logic [5:0]  o_top_ff;
   logic [7:0]  o_width_ff;
   logic [6:0]  o_height_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   mpfd_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // clipping, one set of adders used at setup
   logic signed [17:0] lw, lh, cx0, cy0, cw, ch, ppx, ppy, ppw, pph;
   always_comb begin
      lw = rot_ff[0] ? ROWS_S : COLS_S;
      lh = rot_ff[0] ? COLS_S : ROWS_S;
      cx0 = x_ff; cy0 = y_ff; cw = w_ff; ch = h_ff;
      if (op_ff == OP_FILL) begin
         if (cx0 < 0) begin cw = cw + cx0; cx0 = '0; end
         if (cy0 < 0) begin ch = ch + cy0; cy0 = '0; end
         if (cx0 + cw > lw) cw = lw - cx0;
         if (cy0 + ch > lh) ch = lh - cy0;
      end else begin
         cw = 18'sd1; ch = 18'sd1;
      end
      case (rot_ff)
         2'd1: begin ppx = COLS_S - cy0 - ch; ppy = cx0; ppw = ch; pph = cw; end
         2'd2: begin ppx = COLS_S - cx0 - cw; ppy = ROWS_S - cy0 - ch;
                     ppw = cw; pph = ch; end
         2'd3: begin ppx = cy0; ppy = ROWS_S - cx0 - cw; ppw = ch; pph = cw; end
         default: begin ppx = cx0; ppy = cy0; ppw = cw; pph = ch; end
      endcase
   end

   logic empty_set;
   assign empty_set = (x_ff >= lw) || (y_ff >= lh) || (x_ff < 0 && op_ff != OP_FILL)
                      || (y_ff < 0 && op_ff != OP_FILL) || (cw <= 0) || (ch <= 0);

   // skipped items go straight through one dummy read pass on a single byte
   logic skip_set;
   assign skip_set = (op_ff == OP_FLUSH) || (op_ff > OP_CLEAR)
                     || (op_ff != OP_CLEAR && empty_set);

   // row mask of current page and the new byte for each op
   logic [RW-1:0] pbase;
   logic [7:0] rmask, newb;
   always_comb begin
      pbase = RW'({page_ff, 3'b000});
      for (int i = 0; i < 8; i++) begin
         rmask[i] = (RW'(pbase + RW'(i)) >= py_lo_ff) && (RW'(pbase + RW'(i)) <= py_hi_ff)
                    && (int'(pbase) + i < SCREEN_ROWS);
      end
      if (op_ff == OP_CLEAR) begin
         newb = (color_ff == COLOR_INVERSE) ? ~rd_data :
                (color_ff == COLOR_WHITE) ? BYTE_ONES : 8'h00;
      end else if (op_ff == OP_WRITE) begin
         newb = (color_ff == COLOR_KEEP) ? rd_data : apply_mask(rd_data, pmask_ff, color_ff);
      end else begin
         newb = apply_mask(rd_data, rmask, (color_ff == COLOR_KEEP) ? COLOR_BLACK : color_ff);
      end
   end

   logic [AW-1:0] cur_addr;
   assign cur_addr = AW'(int'(col_ff) + int'(page_ff) * SCREEN_COLS);
   logic changed;
   assign changed = (newb != rd_data);
   logic [RW:0] dirty_row;
   assign dirty_row = (op_ff == OP_WRITE) ? {1'b0, py_lo_ff} : {1'b0, pbase};

   assign wr_en   = (state_ff == S_INIT) ||
                    (state_ff == S_MOD && changed && !skip_ff && op_ff != OP_READ);
   assign wr_addr = (state_ff == S_INIT) ? init_ff : cur_addr;
   assign wr_data = (state_ff == S_INIT) ? 8'h00 : newb;
   assign rd_addr = cur_addr;

   logic last_col, last_page;
   assign last_col  = (col_ff == col_hi_ff);
   assign last_page = (page_ff == page_hi_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT:  if (init_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_SETUP;
         S_SETUP: state_in = S_RD;
         S_RD:    state_in = S_WAIT;
         S_WAIT:  state_in = S_MOD;
         S_MOD:   state_in = S_NEXT;
         S_NEXT:  state_in = (last_col && last_page) ? S_OUT : S_RD;
         S_OUT:   if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff <= '0;
         rot_ff <= '0;
         rsp_valid_ff <= 1'b0;
         bl_ff <= '0;
         br_ff <= (CW+1)'(SCREEN_COLS - 1);
         bt_ff <= '0;
         bb_ff <= (RW+1)'(SCREEN_ROWS - 1);
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) rot_ff <= csr_write_data;
         case (state_ff)
            S_INIT: init_ff <= init_ff + 1'b1;
            S_IDLE: begin
               op_ff <= req_op; color_ff <= req_color;
               x_ff <= 18'(req_pos_x); y_ff <= 18'(req_pos_y);
               w_ff <= 18'(req_rect_w); h_ff <= 18'(req_rect_h);
            end
            S_SETUP: begin
               pix_ff <= 1'b0;
               o_left_ff <= '0; o_top_ff <= '0; o_width_ff <= '0; o_height_ff <= '0;
               skip_ff <= 1'b0;
               col_lo_ff <= CW'(ppx); col_ff <= CW'(ppx);
               col_hi_ff <= skip_set ? CW'(ppx) : CW'(ppx + ppw - 1);
               py_lo_ff <= RW'(ppy); py_hi_ff <= RW'(ppy + pph - 1);
               page_ff <= PW'(ppy >>> 3);
               page_hi_ff <= skip_set ? PW'(ppy >>> 3) : PW'((ppy + pph - 1) >>> 3);
               pmask_ff <= 8'd1 << ppy[2:0];
               if (op_ff == OP_CLEAR) begin
                  col_lo_ff <= '0; col_ff <= '0; col_hi_ff <= CW'(SCREEN_COLS - 1);
                  py_lo_ff <= '0; py_hi_ff <= RW'(SCREEN_ROWS - 1);
                  page_ff <= '0; page_hi_ff <= PW'(PAGES - 1);
               end else if (op_ff == OP_FLUSH) begin
                  skip_ff <= 1'b1;
                  if (br_ff < bl_ff) begin
                     o_left_ff <= '0; o_width_ff <= 8'(SCREEN_COLS);
                  end else begin
                     o_left_ff <= 7'(bl_ff); o_width_ff <= 8'(br_ff - bl_ff + 1'b1);
                  end
                  if (bb_ff < bt_ff) begin
                     o_top_ff <= '0; o_height_ff <= 7'(SCREEN_ROWS);
                  end else begin
                     o_top_ff <= 6'(bt_ff); o_height_ff <= 7'(bb_ff - bt_ff + 1'b1);
                  end
                  bl_ff <= (CW+1)'(SCREEN_COLS - 1); br_ff <= '0;
                  bt_ff <= (RW+1)'(SCREEN_ROWS - 1); bb_ff <= '0;
               end else if (op_ff > OP_CLEAR || empty_set) begin
                  skip_ff <= 1'b1;
               end
            end
            S_RD: ;
            S_WAIT: ;
            S_MOD: begin
               if (op_ff == OP_READ) begin
                  if (!skip_ff) pix_ff <= |(rd_data & pmask_ff);
               end else if (changed && !skip_ff) begin
                  if ({1'b0, col_ff} < bl_ff) bl_ff <= {1'b0, col_ff};
                  if ({1'b0, col_ff} > br_ff) br_ff <= {1'b0, col_ff};
                  if (dirty_row < bt_ff) bt_ff <= dirty_row;
                  if (dirty_row > bb_ff) bb_ff <= dirty_row;
               end
            end
            S_NEXT: begin
               if (last_col) begin
                  col_ff <= col_lo_ff;
                  page_ff <= page_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
               if (last_col && last_page) rsp_valid_ff <= 1'b1;
            end
            S_OUT: if (!rsp_stall) rsp_valid_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_on     = pix_ff;
   assign rsp_dirty_left   = o_left_ff;
   assign rsp_dirty_top    = o_top_ff;
   assign rsp_dirty_width  = o_width_ff;
   assign rsp_dirty_height = o_height_ff;

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("item accepted while result pending");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en) else $error("store written while idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");

endmodule
